[design/sidechain_noise_gate_defines.svh]
// Assertion macros shared by the noise gate modules.
`ifndef SIDECHAIN_NOISE_GATE_DEFINES_SVH
`define SIDECHAIN_NOISE_GATE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SNG_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Overlapping implication checked outside reset.
`define SNG_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/sng_pkg.sv]
// Types, constants and table functions of the sidechain noise gate.
`timescale 1ns / 1ps
package sng_pkg;

  localparam logic [23:0] Q23       = 24'h800000;
  localparam logic [31:0] ENV_FLOOR = 32'd2147;
  localparam logic [24:0] DB_K      = 25'd394566;
  localparam logic [24:0] EXP_K     = 25'd1393318;
  localparam logic signed [31:0] DB_FLOOR = -32'sd7864320;
  localparam logic signed [31:0] DB_BIAS  = 32'sd101008896;

  localparam logic signed [14:0] THRESHOLD_RST = -15'sd5120;
  localparam logic [12:0] RATIO_RST   = 13'd1024;
  localparam logic [12:0] RATIO_UNITY = 13'd256;
  localparam logic [23:0] ATTACK_RST  = 24'd69760;
  localparam logic [23:0] RELEASE_RST = 24'd6989;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_RATIO     = 2'd1,
    REG_ATTACK    = 2'd2,
    REG_RELEASE   = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ENV_MUL, S_ENV_UPD, S_LVL, S_NORM_WAIT,
    S_INT_POS, S_INT_M1, S_INT_M2, S_INT_SUM,
    S_DB_MUL, S_DB_SET, S_CMP, S_MAG_MUL, S_MAG_SET,
    S_EXP_MUL, S_EXP_SET, S_SCL_L, S_SCL_R, S_SCL_RS, S_DONE
  } state_t;

  typedef struct packed {
    logic        done;
    logic [4:0]  lz;
    logic [31:0] x;
  } norm_res_t;

  // Bit-serial squaring log2 in Q30 of a Q30 value in [1, 2).
  function automatic logic [63:0] log2_q30(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    x = x_in;
    r = 64'd0;
    for (int k = 0; k < 30; k++) begin
      x = (x * x) >> 30;
      r = r << 1;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        r = r | 64'd1;
      end
    end
    return r;
  endfunction

  // Largest Q30 value whose log2 does not exceed t.
  function automatic logic [63:0] exp_search(input logic [63:0] t);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd1 << 30;
    hi = (64'd1 << 31) - 64'd1;
    for (int k = 0; k < 32; k++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (log2_q30(mid) <= t) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

endpackage

[design/sng_mul.sv]
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module sng_mul (
  input  logic               clk,
  input  logic signed [33:0] mul_a,
  input  logic        [24:0] mul_b,
  output logic signed [59:0] prod_r
);

  logic signed [59:0] prod_nxt;

  assign prod_nxt = mul_a * $signed({1'b0, mul_b});

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

[design/sng_norm.sv]
// Iterative leading-zero normalizer, one binary step per cycle.
`timescale 1ns / 1ps
module sng_norm import sng_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] val,
  output norm_res_t   res
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [31:0] x_r, x_nxt;
  logic [4:0]  lz_r, lz_nxt;
  logic [4:0]  sh;
  logic        top_zero;

  always_comb begin
    case (step_r)
      3'd0:    sh = 5'd16;
      3'd1:    sh = 5'd8;
      3'd2:    sh = 5'd4;
      3'd3:    sh = 5'd2;
      default: sh = 5'd1;
    endcase
  end

  assign top_zero = (x_r & ~(32'hFFFFFFFF >> sh)) == 32'd0;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    x_nxt    = x_r;
    lz_nxt   = lz_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 3'd0;
      x_nxt    = val;
      lz_nxt   = 5'd0;
    end else if (busy_r) begin
      if (top_zero) begin
        x_nxt  = x_r << sh;
        lz_nxt = lz_r + sh;
      end
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd4) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    lz_r <= lz_nxt;
  end

  assign res.done = done_r;
  assign res.lz   = lz_r;
  assign res.x    = x_r;

endmodule

[design/sng_tab.sv]
// Constant log2 and exp2 interpolation tables, Q23, built at elaboration.
`timescale 1ns / 1ps
module sng_tab import sng_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                               sel_exp,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   idx,
  output logic [24:0]                        entry
);

  logic [24:0] log_tab [TABLE_DEPTH+1];
  logic [24:0] exp_tab [TABLE_DEPTH+1];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_entry
    localparam logic [63:0] TV = (64'(g) << 30) / TABLE_DEPTH;
    localparam logic [63:0] XV = (64'd1 << 30) + TV;
    localparam logic [24:0] LOG_V = 25'((log2_q30(XV) + 64'd64) >> 7);
    localparam logic [24:0] EXP_V = 25'((exp_search(TV) + 64'd64) >> 7);
    assign log_tab[g] = LOG_V;
    assign exp_tab[g] = EXP_V;
  end

  assign log_tab[TABLE_DEPTH] = {1'b0, Q23};
  assign exp_tab[TABLE_DEPTH] = 25'h1000000;

  assign entry = sel_exp ? exp_tab[idx] : log_tab[idx];

endmodule

[design/sidechain_noise_gate.sv]
// Usage: sidechain noise gate, top level with sequencer and datapath.
// Input channel in_*: one stereo sample pair, a sidechain trigger level and a
// restart flag per transaction, taken when in_valid is high and in_stall low.
// Result channel out_*: the gated pair and the gain used, one transaction per
// input transaction, held steady while out_stall is high.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index (threshold,
// ratio, attack, release); write only while the block is idle.
// Each item runs through one shared 34x26 multiplier, a five-step normalizer
// and the interpolation tables under a sequencer. In bypass (unity ratio)
// the sequencer goes straight to scaling the pair; the longest path goes
// through the log and exp interpolations, each using the multiplier twice,
// and the normalizer wait.
// in_stall is high from acceptance until the result is moved into the output
// register; a finished result waits in the sequencer while out_stall holds
// the previous one.
// Reset clears the envelope, loads register defaults and empties the output.
`timescale 1ns / 1ps
`include "sidechain_noise_gate_defines.svh"
module sidechain_noise_gate import sng_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int TABLE_DEPTH  = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_WIDTH-1:0] in_sample_left,
  input  logic [SAMPLE_WIDTH-1:0] in_sample_right,
  input  logic [23:0]             in_trigger_level,
  input  logic                    in_restart,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_WIDTH-1:0] out_left,
  output logic [SAMPLE_WIDTH-1:0] out_right,
  output logic [23:0]             out_gain_applied,
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_index,
  input  logic [23:0]             cfg_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH + 1);
  localparam int PW    = 23 + IDX_W;

  state_t state_r, state_nxt;

  logic signed [14:0] thr_db_r;
  logic [12:0] ratio_r;
  logic [23:0] attack_r, release_r;

  logic [SAMPLE_WIDTH-1:0] samp_l_r, samp_l_nxt, samp_r_r, samp_r_nxt;
  logic [23:0] trig_r, trig_nxt;
  logic [31:0] env_r, env_nxt;
  logic        rise_r, rise_nxt;
  logic [4:0]  p_r, p_nxt;
  logic [22:0] frac_r, frac_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [49:0] acc_r, acc_nxt;
  logic [24:0] ival_r, ival_nxt;
  logic signed [31:0] db_r, db_nxt;
  logic [32:0] mag_r, mag_nxt;
  logic [4:0]  n_r, n_nxt;
  logic        exp_sel_r, exp_sel_nxt;
  logic [23:0] gain_r, gain_nxt;
  logic [SAMPLE_WIDTH-1:0] res_l_r, res_l_nxt, res_r_r, res_r_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_left_r, out_right_r;
  logic [23:0] out_gain_r;
  logic        out_load;

  logic signed [33:0] mul_a;
  logic        [24:0] mul_b;
  logic signed [59:0] prod_r;
  logic [IDX_W-1:0]   tab_idx;
  logic [24:0]        tab_entry;
  logic               norm_start;
  norm_res_t          norm_res;

  logic        accept;
  logic [31:0] trig32;
  logic        rise;
  logic [31:0] env_diff;
  logic [IDX_W-1:0] pos_idx;
  logic [22:0] pos_rem;
  logic signed [31:0] thr32;
  logic [13:0] rm1;
  logic [33:0] e_val;
  logic [49:0] int_sum;
  logic [24:0] int_val;
  logic [32:0] db_arg;

  sng_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  sng_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .val   (env_r),
    .res   (norm_res)
  );

  sng_tab #(.TABLE_DEPTH(TABLE_DEPTH)) u_tab (
    .sel_exp (exp_sel_r),
    .idx     (tab_idx),
    .entry   (tab_entry)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign trig32   = {trig_r, 8'd0};
  assign rise     = trig32 > env_r;
  assign env_diff = rise ? (trig32 - env_r) : (env_r - trig32);
  assign pos_idx  = pos_r[PW-1:23];
  assign pos_rem  = pos_r[22:0];
  assign thr32    = {{9{thr_db_r[14]}}, thr_db_r, 8'd0};
  assign rm1      = (ratio_r > RATIO_UNITY) ? 14'(ratio_r - RATIO_UNITY) : 14'd0;
  assign e_val    = prod_r[49:16];
  assign int_sum  = acc_r + prod_r[49:0];
  assign int_val  = int_sum[47:23];
  assign db_arg   = {1'b0, 9'(p_r) + 9'd225, 23'd0} + 33'(ival_r);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (accept) begin
                     state_nxt = (ratio_r == RATIO_UNITY) ? S_SCL_L : S_ENV_MUL;
                   end
      S_ENV_MUL:   state_nxt = S_ENV_UPD;
      S_ENV_UPD:   state_nxt = S_LVL;
      S_LVL:       state_nxt = (env_r <= ENV_FLOOR) ? S_CMP : S_NORM_WAIT;
      S_NORM_WAIT: if (norm_res.done) begin
                     state_nxt = S_INT_POS;
                   end
      S_INT_POS:   state_nxt = S_INT_M1;
      S_INT_M1:    state_nxt = S_INT_M2;
      S_INT_M2:    state_nxt = S_INT_SUM;
      S_INT_SUM:   state_nxt = exp_sel_r ? S_SCL_L : S_DB_MUL;
      S_DB_MUL:    state_nxt = S_DB_SET;
      S_DB_SET:    state_nxt = S_CMP;
      S_CMP:       state_nxt = (db_r >= thr32) ? S_SCL_L : S_MAG_MUL;
      S_MAG_MUL:   state_nxt = S_MAG_SET;
      S_MAG_SET:   state_nxt = S_EXP_MUL;
      S_EXP_MUL:   state_nxt = S_EXP_SET;
      S_EXP_SET:   begin
        if (e_val[22:0] == 23'd0 || e_val[33:23] >= 11'd24) state_nxt = S_SCL_L;
        else state_nxt = S_INT_POS;
      end
      S_SCL_L:     state_nxt = S_SCL_R;
      S_SCL_R:     state_nxt = S_SCL_RS;
      S_SCL_RS:    state_nxt = S_DONE;
      S_DONE:      if (out_load) begin
                     state_nxt = S_IDLE;
                   end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Unit controls: multiplier operands, table address, normalizer start.
  always_comb begin
    mul_a      = 34'sd0;
    mul_b      = 25'd0;
    tab_idx    = pos_idx;
    norm_start = 1'b0;
    case (state_r)
      S_ENV_MUL: begin
        mul_a = $signed({2'b00, env_diff});
        mul_b = rise ? {1'b0, attack_r} : {1'b0, release_r};
      end
      S_LVL:     norm_start = (env_r > ENV_FLOOR);
      S_INT_M1: begin
        mul_a = $signed(34'(Q23 - {1'b0, pos_rem}));
        mul_b = tab_entry;
      end
      S_INT_M2: begin
        tab_idx = pos_idx + IDX_W'(1);
        mul_a   = $signed(34'(pos_rem));
        mul_b   = tab_entry;
      end
      S_DB_MUL: begin
        mul_a = $signed({1'b0, db_arg});
        mul_b = DB_K;
      end
      S_MAG_MUL: begin
        mul_a = 34'(thr32 - db_r);
        mul_b = 25'(rm1);
      end
      S_EXP_MUL: begin
        mul_a = $signed({1'b0, mag_r});
        mul_b = EXP_K;
      end
      S_SCL_L: begin
        mul_a = 34'($signed(samp_l_r));
        mul_b = {1'b0, gain_r};
      end
      S_SCL_R: begin
        mul_a = 34'($signed(samp_r_r));
        mul_b = {1'b0, gain_r};
      end
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    samp_l_nxt  = samp_l_r;
    samp_r_nxt  = samp_r_r;
    trig_nxt    = trig_r;
    env_nxt     = env_r;
    rise_nxt    = rise_r;
    p_nxt       = p_r;
    frac_nxt    = frac_r;
    pos_nxt     = pos_r;
    acc_nxt     = acc_r;
    ival_nxt    = ival_r;
    db_nxt      = db_r;
    mag_nxt     = mag_r;
    n_nxt       = n_r;
    exp_sel_nxt = exp_sel_r;
    gain_nxt    = gain_r;
    res_l_nxt   = res_l_r;
    res_r_nxt   = res_r_r;
    case (state_r)
      S_IDLE: if (accept) begin
        samp_l_nxt  = in_sample_left;
        samp_r_nxt  = in_sample_right;
        trig_nxt    = in_trigger_level;
        exp_sel_nxt = 1'b0;
        gain_nxt    = Q23;
        if (in_restart) env_nxt = 32'd0;
      end
      S_ENV_MUL: rise_nxt = rise;
      S_ENV_UPD: env_nxt = rise_r ? (env_r + prod_r[55:24]) : (env_r - prod_r[55:24]);
      S_LVL:     if (env_r <= ENV_FLOOR) db_nxt = DB_FLOOR;
      S_NORM_WAIT: begin
        p_nxt    = 5'd31 - norm_res.lz;
        frac_nxt = norm_res.x[30:8];
      end
      S_INT_POS: pos_nxt = PW'(frac_r) * PW'(TABLE_DEPTH);
      S_INT_M2:  acc_nxt = prod_r[49:0];
      S_INT_SUM: begin
        if (exp_sel_r) gain_nxt = 24'(int_val >> (n_r + 5'd1));
        else ival_nxt = int_val;
      end
      S_DB_SET:  db_nxt = $signed(32'(prod_r[52:23])) - DB_BIAS;
      S_MAG_SET: mag_nxt = prod_r[40:8];
      S_EXP_SET: begin
        n_nxt = e_val[27:23];
        if (e_val[22:0] == 23'd0) begin
          gain_nxt = (e_val[33:23] >= 11'd24) ? 24'd0 : (Q23 >> e_val[27:23]);
        end else if (e_val[33:23] >= 11'd24) begin
          gain_nxt = 24'd0;
        end else begin
          frac_nxt    = 23'(Q23 - {1'b0, e_val[22:0]});
          exp_sel_nxt = 1'b1;
        end
      end
      S_SCL_R:  res_l_nxt = prod_r[23+SAMPLE_WIDTH-1:23];
      S_SCL_RS: res_r_nxt = prod_r[23+SAMPLE_WIDTH-1:23];
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      env_r       <= 32'd0;
      out_valid_r <= 1'b0;
      thr_db_r    <= THRESHOLD_RST;
      ratio_r     <= RATIO_RST;
      attack_r    <= ATTACK_RST;
      release_r   <= RELEASE_RST;
      exp_sel_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      env_r       <= env_nxt;
      out_valid_r <= out_valid_nxt;
      exp_sel_r   <= exp_sel_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_THRESHOLD: thr_db_r  <= $signed(cfg_data[14:0]);
          REG_RATIO:     ratio_r   <= cfg_data[12:0];
          REG_ATTACK:    attack_r  <= cfg_data;
          REG_RELEASE:   release_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    samp_l_r <= samp_l_nxt;
    samp_r_r <= samp_r_nxt;
    trig_r   <= trig_nxt;
    rise_r   <= rise_nxt;
    p_r      <= p_nxt;
    frac_r   <= frac_nxt;
    pos_r    <= pos_nxt;
    acc_r    <= acc_nxt;
    ival_r   <= ival_nxt;
    db_r     <= db_nxt;
    mag_r    <= mag_nxt;
    n_r      <= n_nxt;
    gain_r   <= gain_nxt;
    res_l_r  <= res_l_nxt;
    res_r_r  <= res_r_nxt;
    if (out_load) begin
      out_left_r  <= res_l_r;
      out_right_r <= res_r_r;
      out_gain_r  <= gain_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left         = out_left_r;
  assign out_right        = out_right_r;
  assign out_gain_applied = out_gain_r;

  `SNG_IMPLIES(a_gain_range, out_valid_r, out_gain_r <= Q23, "gain above unity")
  `SNG_IMPLIES(a_busy_after_accept, accept, ##1 in_stall, "item accepted while busy")
  `SNG_IMPLIES(a_done_loads, (state_r == S_DONE) && !out_valid_r, ##1 out_valid_r,
               "finished result not loaded")
  `SNG_CHECK(a_idle_norm, !(norm_start && state_r != S_LVL), "normalizer started late")

endmodule
